[rtl/nsh_pkg.sv]
// nsh_pkg: shared types and constants of the nearest segment hit unit
// transfer payload structs, fixed-point result format, register indexes
// no dependencies
package nsh_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned T_BITS    = FRAC_BITS + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [T_BITS-1:0] T_ONE        = T_BITS'(1) << FRAC_BITS;
  localparam logic [T_BITS-1:0] BEST_T_RESET = T_ONE + T_BITS'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] seg_start_x;
    logic signed [DATA_W-1:0] seg_start_y;
    logic signed [DATA_W-1:0] seg_offset_x;
    logic signed [DATA_W-1:0] seg_offset_y;
    logic                     last_segment;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic [T_BITS-1:0]        hit_t;
    logic signed [DATA_W-1:0] hit_offset_x;
    logic signed [DATA_W-1:0] hit_offset_y;
  } out_item_t;

endpackage

[rtl/nsh_cross_unit.sv]
// nsh_cross_unit: three 2d cross products on one shared signed multiplier
// six products, one per cycle, accumulated into den, u and t numerators
// depends on nothing but its parameter
module nsh_cross_unit #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [COORD_BITS-1:0]  ox_i,
  input  logic signed [COORD_BITS-1:0]  oy_i,
  input  logic signed [COORD_BITS-1:0]  rx_i,
  input  logic signed [COORD_BITS-1:0]  ry_i,
  input  logic signed [COORD_BITS:0]    dx_i,
  input  logic signed [COORD_BITS:0]    dy_i,
  output logic                          done_o,
  output logic signed [2*COORD_BITS+2:0] den_o,
  output logic signed [2*COORD_BITS+2:0] un_o,
  output logic signed [2*COORD_BITS+2:0] tn_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = PW + 1;
  localparam logic [2:0] LAST_STEP = 3'd6;

  logic              busy_q, busy_d;
  logic [2:0]        step_q, step_d;
  logic              done_q, done_d;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod, prod_q;
  logic signed [XW-1:0] den_q, un_q, tn_q, acc_in, acc_out;
  logic [2:0]        idx;

  // operand select: ox*ry, oy*rx, dx*ry, dy*rx, dx*oy, dy*ox
  always_comb begin
    unique case (step_q)
      3'd0: begin op_a = DW'(ox_i); op_b = DW'(ry_i); end
      3'd1: begin op_a = DW'(oy_i); op_b = DW'(rx_i); end
      3'd2: begin op_a = dx_i;      op_b = DW'(ry_i); end
      3'd3: begin op_a = dy_i;      op_b = DW'(rx_i); end
      3'd4: begin op_a = dx_i;      op_b = DW'(oy_i); end
      3'd5: begin op_a = dy_i;      op_b = DW'(ox_i); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod = op_a * op_b;
  // product register holds the product of the step before
  assign idx  = step_q - 3'd1;

  always_comb begin
    unique case (idx[2:1])
      2'd0:    acc_in = den_q;
      2'd1:    acc_in = un_q;
      default: acc_in = tn_q;
    endcase
    if (idx[0]) begin
      acc_out = acc_in - XW'(prod_q);
    end else begin
      acc_out = XW'(prod_q);
    end
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prod_q <= prod;
      if (step_q != 3'd0) begin
        unique case (idx[2:1])
          2'd0:    den_q <= acc_out;
          2'd1:    un_q  <= acc_out;
          default: tn_q  <= acc_out;
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign den_o  = den_q;
  assign un_o   = un_q;
  assign tn_o   = tn_q;

endmodule

[rtl/nsh_frac_div.sv]
// nsh_frac_div: restoring divider, floor(num * 2^FRAC_BITS / den) for num <= den
// one quotient bit per cycle, T_BITS quotient bits per division
// depends on nsh_pkg
module nsh_frac_div #(
  parameter int unsigned NUM_W = 66
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [NUM_W-1:0]          den_i,
  output logic                      done_o,
  output logic [nsh_pkg::T_BITS-1:0] quot_o
);

  import nsh_pkg::*;

  localparam int unsigned CNT_W = $clog2(T_BITS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(T_BITS - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] rem_q, den_q;
  logic [T_BITS-1:0] quot_q;
  logic [NUM_W:0]   trial, diff;
  logic             ge;

  // first step takes the integer bit without a shift
  assign trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = !diff[NUM_W];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_CNT) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      quot_q <= {quot_q[T_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/nearest_segment_hit_unit.sv]
// nearest_segment_hit_unit: nearest crossing of a configured ray with a segment stream
// top level: sequencer, nearest-hit state, result register
// depends on nsh_pkg, nsh_cross_unit, nsh_frac_div
//
// usage
//   the ray (origin and offset, signed Q16.16) sits in four registers written
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i by the user only while the block
//   is idle (the block itself leaves this unchecked); segments arrive on the in_*
//   valid/ready channel, one transfer per segment; the segment flagged
//   last_segment closes the list and yields exactly one transfer on the out_*
//   channel: hit flag, nearest t (Q1.16) and that segment's offset, all zero
//   when nothing was hit; one segment at a time: in_ready_o is high only while
//   the sequencer idles; a missed or parallel segment goes from ST_CROSS
//   (the shared multiplier) through ST_NORM and ST_TEST to ST_EMIT, a candidate
//   hit from ST_TEST through ST_DIV (17 quotient bits on the divider) and
//   ST_UPDATE to ST_EMIT; the result sits in an output register; if the
//   receiver stalls, the block holds the next list's last segment until that
//   register frees up; reset clears the ray registers to zero and the
//   nearest-hit state to "no hit"; there is no clearing pass
module nearest_segment_hit_unit #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [nsh_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [nsh_pkg::DATA_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  nsh_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output nsh_pkg::out_item_t                   out_data_o
);

  import nsh_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned XW = 2 * DW + 1;
  localparam int unsigned MW = XW - 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CROSS  = 3'd1;
  localparam logic [2:0] ST_NORM   = 3'd2;
  localparam logic [2:0] ST_TEST   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;

  // ray registers
  logic [DATA_W-1:0] org_x_q, org_y_q, off_x_q, off_y_q;
  logic signed [CW-1:0] px, py, rx, ry, sx, sy;

  // current segment
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [CW-1:0] ox_q, oy_q;
  logic                 last_q;

  // cross products, sign-normalized
  logic                 cross_done;
  logic signed [XW-1:0] den, un, tn;
  logic                 den_zero_q;
  logic signed [XW-1:0] dn_q, unn_q, tnn_q;
  logic                 in_range;

  // divider
  logic                 div_start;
  logic                 div_done;
  logic [T_BITS-1:0]    quot;

  // nearest-hit state
  logic [T_BITS-1:0]        best_t_q;
  logic                     have_hit_q;
  logic signed [DATA_W-1:0] best_ox_q, best_oy_q;

  // result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  logic in_xfer, emit_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // coordinates are the low COORD_BITS bits, two's complement
  assign px = org_x_q[CW-1:0];
  assign py = org_y_q[CW-1:0];
  assign rx = off_x_q[CW-1:0];
  assign ry = off_y_q[CW-1:0];
  assign sx = in_data_i.seg_start_x[CW-1:0];
  assign sy = in_data_i.seg_start_y[CW-1:0];

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      off_x_q <= '0;
      off_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: org_x_q <= cfg_wdata_i;
        REG_ORIGIN_Y: org_y_q <= cfg_wdata_i;
        REG_OFFSET_X: off_x_q <= cfg_wdata_i;
        REG_OFFSET_Y: off_y_q <= cfg_wdata_i;
      endcase
    end
  end

  // segment capture: origin minus start is formed once here
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dx_q   <= DW'(px) - DW'(sx);
      dy_q   <= DW'(py) - DW'(sy);
      ox_q   <= in_data_i.seg_offset_x[CW-1:0];
      oy_q   <= in_data_i.seg_offset_y[CW-1:0];
      last_q <= in_data_i.last_segment;
    end
  end

  nsh_cross_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .ox_i    (ox_q),
    .oy_i    (oy_q),
    .rx_i    (rx),
    .ry_i    (ry),
    .dx_i    (dx_q),
    .dy_i    (dy_q),
    .done_o  (cross_done),
    .den_o   (den),
    .un_o    (un),
    .tn_o    (tn)
  );

  // flip all three when den is negative so the divisor is positive
  always_ff @(posedge clk_i) begin
    if (state_q == ST_NORM) begin
      den_zero_q <= (den == '0);
      if (den[XW-1]) begin
        dn_q  <= -den;
        unn_q <= -un;
        tnn_q <= -tn;
      end else begin
        dn_q  <= den;
        unn_q <= un;
        tnn_q <= tn;
      end
    end
  end

  // exact test of u and t in [0,1] on the full-width numerators
  assign in_range = !den_zero_q
                 && !unn_q[XW-1] && (unn_q <= dn_q)
                 && !tnn_q[XW-1] && (tnn_q <= dn_q);

  assign div_start = (state_q == ST_TEST) && in_range;

  nsh_frac_div #(
    .NUM_W (MW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tnn_q[MW-1:0]),
    .den_i   (dn_q[MW-1:0]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // result goes out only on the last segment, once the output slot is free
  assign emit_fire = (state_q == ST_EMIT) && last_q && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_CROSS;
      ST_CROSS:  if (cross_done) state_d = ST_NORM;
      ST_NORM:   state_d = ST_TEST;
      ST_TEST:   state_d = in_range ? ST_DIV : ST_EMIT;
      ST_DIV:    if (div_done) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_EMIT;
      ST_EMIT:   if (!last_q || emit_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // nearest-hit bookkeeping: strict less-than keeps the earlier segment on ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_t_q   <= BEST_T_RESET;
      have_hit_q <= 1'b0;
      best_ox_q  <= '0;
      best_oy_q  <= '0;
    end else if (emit_fire) begin
      best_t_q   <= BEST_T_RESET;
      have_hit_q <= 1'b0;
      best_ox_q  <= '0;
      best_oy_q  <= '0;
    end else if ((state_q == ST_UPDATE) && (quot < best_t_q)) begin
      best_t_q   <= quot;
      have_hit_q <= 1'b1;
      best_ox_q  <= DATA_W'(ox_q);
      best_oy_q  <= DATA_W'(oy_q);
    end
  end

  // output register
  assign out_valid_d = (out_valid_q && !out_ready_i) || emit_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.hit          <= have_hit_q;
      out_q.hit_t        <= have_hit_q ? best_t_q : '0;
      out_q.hit_offset_x <= have_hit_q ? best_ox_q : '0;
      out_q.hit_offset_y <= have_hit_q ? best_oy_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_cross_done_in_cross : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cross_done |-> (state_q == ST_CROSS))
    else $error("cross unit finished outside its wait state");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

  a_clear_after_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (!have_hit_q && (best_t_q == BEST_T_RESET) && out_valid_o))
    else $error("nearest-hit state not cleared after a result");

  a_best_t_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_hit_q |-> (best_t_q <= T_ONE))
    else $error("kept hit fraction above one");

  a_no_emit_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit_fire)
    else $error("result overwrote a stalled transfer");

endmodule
